// File: src/rcf_pkg.sv
// Package for the rectangle containment filter.
// Holds default sizes, the controller state type and the command and status
// structs shared by the controller and the datapath. Depends on nothing.
package rcf_pkg;

    // Default capacity of the rectangle store and coordinate width.
    localparam int unsigned MAX_RECTS_DEF  = 32;
    localparam int unsigned COORD_BITS_DEF = 12;

    // Controller states, one-hot coded.
    typedef enum logic [4:0] {
        ST_LOAD   = 5'b00001,
        ST_FETCH  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_KEEP   = 5'b01000,
        ST_FINISH = 5'b10000
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // an input item is accepted this cycle
        logic fetch;   // read candidate i and the first rival
        logic scan;    // compare the candidate against one rival
        logic keep;    // candidate survived: move it to the pending slot
        logic next_i;  // step on to the next candidate
        logic finish;  // emit the closing result and empty the store
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;   // candidate covered, or last rival compared
        logic covered;     // candidate lies inside the rival under test
        logic last_i;      // candidate is the last stored rectangle
        logic pend_valid;  // a survivor waits in the pending slot
        logic out_free;    // output register can take a result this cycle
    } ctrl_status_t;

endpackage

// File: src/rcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for both copies of the rectangle store. No dependencies.
module rcf_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/rcf_datapath.sv
// Datapath of the rectangle containment filter: two copies of the rectangle
// store, candidate and rival counters, the edge comparator, the pending
// survivor slot and the output register. Depends on rcf_pkg and rcf_ram.
module rcf_datapath
    import rcf_pkg::*;
#(
    parameter int unsigned MAX_RECTS  = MAX_RECTS_DEF,
    parameter int unsigned COORD_BITS = COORD_BITS_DEF,
    localparam int unsigned RW = 4 * COORD_BITS
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  ctrl_cmd_t       cmd,
    output ctrl_status_t    status,
    input  logic [RW-1:0]   in_rect,
    input  logic            m_tready,
    output logic            out_valid,
    output logic [RW-1:0]   out_rect,
    output logic            out_none,
    output logic            out_ovf,
    output logic            out_end
);

    localparam int unsigned IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int unsigned CW = $clog2(MAX_RECTS + 1);
    localparam int unsigned CB = COORD_BITS;

    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] jd_reg, jd_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [RW-1:0] pend_rect_reg, pend_rect_next;
    logic          out_valid_reg, out_valid_next;
    logic [RW-1:0] out_rect_reg, out_rect_next;
    logic          out_none_reg, out_none_next;
    logic          out_ovf_reg, out_ovf_next;
    logic          out_end_reg, out_end_next;

    logic          wr_en;
    logic [RW-1:0] cand_rect;
    logic [RW-1:0] rival_rect;
    logic          has_room;
    logic          out_free;
    logic          inside_hit;
    logic          covered_now;
    logic          last_rival;
    logic [CW-1:0] count_m1;

    // Both store copies take every write; one is read at the candidate,
    // the other at the rival.
    assign has_room = (count_reg < CW'(MAX_RECTS));
    assign wr_en    = cmd.load && has_room;

    rcf_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_RECTS)
    ) u_cand_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (in_rect),
        .rd_addr (i_reg),
        .rd_data (cand_rect)
    );

    rcf_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_RECTS)
    ) u_rival_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (in_rect),
        .rd_addr (j_reg),
        .rd_data (rival_rect)
    );

    // Edge test: the candidate lies inside the rival when its left and top
    // edges are not before the rival's and its right and bottom edges are
    // not beyond them. Sums are one bit wider than a coordinate.
    always_comb begin
        logic [CB:0] cand_right, cand_bottom, rival_right, rival_bottom;
        cand_right   = {1'b0, cand_rect[CB-1:0]}      + {1'b0, cand_rect[3*CB-1:2*CB]};
        cand_bottom  = {1'b0, cand_rect[2*CB-1:CB]}   + {1'b0, cand_rect[4*CB-1:3*CB]};
        rival_right  = {1'b0, rival_rect[CB-1:0]}     + {1'b0, rival_rect[3*CB-1:2*CB]};
        rival_bottom = {1'b0, rival_rect[2*CB-1:CB]}  + {1'b0, rival_rect[4*CB-1:3*CB]};
        inside_hit   = (cand_rect[CB-1:0] >= rival_rect[CB-1:0])
                    && (cand_rect[2*CB-1:CB] >= rival_rect[2*CB-1:CB])
                    && (cand_right <= rival_right)
                    && (cand_bottom <= rival_bottom);
    end

    // A rectangle never counts as covered by itself.
    assign count_m1    = count_reg - CW'(1);
    assign covered_now = (jd_reg != i_reg) && inside_hit;
    assign last_rival  = (CW'(jd_reg) == count_m1);
    assign out_free    = !out_valid_reg || m_tready;

    assign status.scan_done  = covered_now || last_rival;
    assign status.covered    = covered_now;
    assign status.last_i     = (CW'(i_reg) == count_m1);
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    // Store fill count and overflow mark.
    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.load) begin
            if (has_room) begin
                count_next = count_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.finish) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    // Candidate and rival counters; jd_reg names the rival whose data is
    // on the read port this cycle, j_reg the one being addressed.
    always_comb begin
        i_next  = i_reg;
        j_next  = j_reg;
        jd_next = jd_reg;
        if (cmd.fetch) begin
            j_next  = IW'(1);
            jd_next = '0;
        end
        if (cmd.scan) begin
            if (status.scan_done) begin
                j_next = '0;
            end else begin
                j_next  = j_reg + IW'(1);
                jd_next = jd_reg + IW'(1);
            end
        end
        if (cmd.next_i) begin
            i_next = i_reg + IW'(1);
        end
        if (cmd.finish) begin
            i_next = '0;
        end
    end

    // Pending survivor slot and output register. A survivor is held back
    // until the next one is found, so that the last one can carry the end
    // mark.
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_rect_next  = pend_rect_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_rect_next   = out_rect_reg;
        out_none_next   = out_none_reg;
        out_ovf_next    = out_ovf_reg;
        out_end_next    = out_end_reg;
        if (cmd.keep) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_rect_next  = pend_rect_reg;
                out_none_next  = 1'b0;
                out_ovf_next   = ovf_reg;
                out_end_next   = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_rect_next  = cand_rect;
        end
        if (cmd.finish) begin
            out_valid_next  = 1'b1;
            out_rect_next   = pend_valid_reg ? pend_rect_reg : '0;
            out_none_next   = !pend_valid_reg;
            out_ovf_next    = ovf_reg;
            out_end_next    = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            jd_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            jd_reg         <= jd_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        pend_rect_reg <= pend_rect_next;
        out_rect_reg  <= out_rect_next;
        out_none_reg  <= out_none_next;
        out_ovf_reg   <= out_ovf_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid = out_valid_reg;
    assign out_rect  = out_rect_reg;
    assign out_none  = out_none_reg;
    assign out_ovf   = out_ovf_reg;
    assign out_end   = out_end_reg;

endmodule

// File: src/rcf_ctrl.sv
// Controller of the rectangle containment filter: loads the list, then
// walks each candidate against the rivals until one covers it or none is
// left, and sequences the results. Depends on rcf_pkg.
module rcf_ctrl
    import rcf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tlast,
    output logic         s_tready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    if (s_tlast) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    if (!status.covered) begin
                        state_next = ST_KEEP;
                    end else if (status.last_i) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.next_i = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_KEEP: begin
                if (!status.pend_valid || status.out_free) begin
                    cmd.keep = 1'b1;
                    if (status.last_i) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.next_i = 1'b1;
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/rect_containment_filter_unit.sv
// Top level of the rectangle containment filter.
// Instantiates the controller rcf_ctrl and the datapath rcf_datapath; uses rcf_pkg.
//
// Rectangles arrive one item per cycle while a list is loading and are
// stored until the item with tlast closes the list; a list longer than
// MAX_RECTS keeps its first MAX_RECTS rectangles and marks every result
// as overflowed. After the closing item each stored rectangle is compared,
// one rival per cycle, with the others by a single edge comparator fed from
// two read ports of the store: each rectangle takes a fetch step and then
// compare steps until a rival covers it or none is left, a survivor takes
// one more step, and a closing step ends the list; the result side can
// stall the survivor and closing steps. Survivors leave in arrival order,
// the last marked with tlast; if none survive a single result with
// none_kept set is given. No input is accepted while a list is being
// filtered.
module rect_containment_filter_unit
    import rcf_pkg::*;
#(
    parameter int unsigned MAX_RECTS  = MAX_RECTS_DEF,
    parameter int unsigned COORD_BITS = COORD_BITS_DEF,
    localparam int unsigned RW = 4 * COORD_BITS,
    localparam int unsigned DW = ((RW + 7) / 8) * 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    // Input rectangles
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [DW-1:0] s_tdata,   // rect_x, rect_y, rect_width, rect_height
    input  logic          s_tlast,   // last_rect
    // Surviving rectangles
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [DW-1:0] m_tdata,   // kept_x, kept_y, kept_width, kept_height
    output logic [1:0]    m_tuser,   // none_kept, overflowed
    output logic          m_tlast    // end_of_list
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic [RW-1:0] out_rect;
    logic          out_none;
    logic          out_ovf;

    // Sequencer.
    rcf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Store, comparator and output register.
    rcf_datapath #(
        .MAX_RECTS  (MAX_RECTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .in_rect   (s_tdata[RW-1:0]),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .out_rect  (out_rect),
        .out_none  (out_none),
        .out_ovf   (out_ovf),
        .out_end   (m_tlast)
    );

    // Result packing, padded with zeros to whole bytes.
    assign m_tdata = DW'(out_rect);
    assign m_tuser = {out_ovf, out_none};

endmodule
